[hdl/assert_macros.svh]
// Assertion macros shared by the checker files.
// Properties are sampled on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DSC_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dsc assertion failed");

// Next-cycle implication.
`define DSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dsc assertion failed");

`endif

[hdl/dsc_pkg.sv]
// Package for the distinct subsequence counter: sizes, register indexes,
// shared types and the saturating add. No dependencies.
package dsc_pkg;

    localparam int PATTERN_MAX   = 16;
    localparam int COUNT_BITS    = 32;
    localparam int LEN_W         = 5;
    localparam int PAT_REG_W     = 64;
    localparam int PAT_REG_BYTES = PAT_REG_W / 8;
    localparam int CFG_ADDR_W    = 2;
    localparam int MATCH_W       = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_HIGH   = 2'd2;

    typedef logic [COUNT_BITS-1:0] t_count;

    localparam t_count COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam t_count COUNT_ONE = t_count'(1);

    typedef struct packed {
        logic       en;
        logic       clear;
        logic [7:0] text;
    } t_step;

    typedef struct packed {
        logic [MATCH_W-1:0] match_count;
        logic               saturated;
        logic               is_final;
    } t_result;

    function automatic t_count sat_add(input t_count a, input t_count b);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
    endfunction

endpackage

[hdl/dsc_cell.sv]
// One pattern position of the counter chain: holds the count of its prefix.
// Depends on dsc_pkg.
module dsc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dsc_pkg::t_step  i_step,
    input  logic [7:0]      i_pat_byte,
    input  dsc_pkg::t_count i_below,
    output dsc_pkg::t_count o_count,
    output dsc_pkg::t_count o_next
);

    dsc_pkg::t_count r_count;
    dsc_pkg::t_count n_count;
    dsc_pkg::t_count w_own;

    always_comb begin
        w_own = i_step.clear ? '0 : r_count;
        if (i_pat_byte == i_step.text) begin
            n_count = dsc_pkg::sat_add(w_own, i_below);
        end else begin
            n_count = w_own;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_step.en) begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
    assign o_next  = n_count;

endmodule

[hdl/dsc_skid.sv]
// Output register with skid entry for the result words.
// Depends on dsc_pkg.
module dsc_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dsc_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    output dsc_pkg::t_result o_data,
    input  logic             i_ready
);

    logic             r_out_valid;
    logic             r_skid_valid;
    dsc_pkg::t_result r_out;
    dsc_pkg::t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[hdl/distinct_subsequence_counter.sv]
// Distinct subsequence counter: counts the ways a configured pattern of up to
// PATTERN_MAX bytes occurs as a subsequence of a streamed text. One text word
// is taken every cycle while s_tready is high. The rate is set by the chain of
// cells, each updating its prefix count with one saturating adder per cycle
// from its lower neighbor's stored count. A two-entry output stage absorbs
// back-pressure; s_tready drops only when both entries hold results. The user
// must ensure configuration is written only while the stream is idle; the
// block does not enforce this. Depends on dsc_pkg, dsc_cell and dsc_skid.
module distinct_subsequence_counter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dsc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [dsc_pkg::PAT_REG_W-1:0]      i_cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // text_byte
    input  logic                               s_tuser,  // first_byte
    input  logic                               s_tlast,  // last_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dsc_pkg::MATCH_W-1:0]        m_tdata,  // match_count
    output logic                               m_tuser,  // saturated
    output logic                               m_tlast   // is_final
);

    logic [dsc_pkg::LEN_W-1:0]     r_len;
    logic [dsc_pkg::PAT_REG_W-1:0] r_pat_lo;
    logic [dsc_pkg::PAT_REG_W-1:0] r_pat_hi;

    dsc_pkg::t_step   w_step;
    dsc_pkg::t_count  w_count [dsc_pkg::PATTERN_MAX];
    dsc_pkg::t_count  w_next  [dsc_pkg::PATTERN_MAX];
    dsc_pkg::t_count  w_below [dsc_pkg::PATTERN_MAX];
    logic [7:0]       w_pat   [dsc_pkg::PATTERN_MAX];
    dsc_pkg::t_count  w_sel;
    dsc_pkg::t_result w_res;
    dsc_pkg::t_result w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_pat_lo <= '0;
            r_pat_hi <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dsc_pkg::REG_PATTERN_LENGTH: r_len    <= i_cfg_wdata[dsc_pkg::LEN_W-1:0];
                dsc_pkg::REG_PATTERN_LOW:    r_pat_lo <= i_cfg_wdata;
                dsc_pkg::REG_PATTERN_HIGH:   r_pat_hi <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_step.en    = s_tvalid && s_tready;
    assign w_step.clear = s_tuser;
    assign w_step.text  = s_tdata;

    for (genvar j = 0; j < dsc_pkg::PATTERN_MAX; j++) begin : g_cell
        if (j < dsc_pkg::PAT_REG_BYTES) begin : g_lo
            assign w_pat[j] = r_pat_lo[8*j +: 8];
        end else if (j < 2*dsc_pkg::PAT_REG_BYTES) begin : g_hi
            assign w_pat[j] = r_pat_hi[8*(j-dsc_pkg::PAT_REG_BYTES) +: 8];
        end else begin : g_none
            assign w_pat[j] = 8'h00;
        end

        if (j == 0) begin : g_first
            assign w_below[j] = dsc_pkg::COUNT_ONE;
        end else begin : g_rest
            assign w_below[j] = s_tuser ? '0 : w_count[j-1];
        end

        dsc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_step     (w_step),
            .i_pat_byte (w_pat[j]),
            .i_below    (w_below[j]),
            .o_count    (w_count[j]),
            .o_next     (w_next[j])
        );
    end

    // length zero reads one; lengths past the chain read the last cell
    always_comb begin
        w_sel = dsc_pkg::COUNT_ONE;
        for (int j = 0; j < dsc_pkg::PATTERN_MAX; j++) begin
            if (int'(r_len) == j + 1 ||
                (j == dsc_pkg::PATTERN_MAX - 1 && int'(r_len) > dsc_pkg::PATTERN_MAX)) begin
                w_sel = w_next[j];
            end
        end
        w_res.match_count = dsc_pkg::MATCH_W'(w_sel);
        w_res.saturated   = (w_sel == dsc_pkg::COUNT_MAX);
        w_res.is_final    = s_tlast;
    end

    dsc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_step.en),
        .i_data  (w_res),
        .o_ready (s_tready),
        .o_valid (m_tvalid),
        .o_data  (w_out),
        .i_ready (m_tready)
    );

    assign m_tdata = w_out.match_count;
    assign m_tuser = w_out.saturated;
    assign m_tlast = w_out.is_final;

endmodule

[hdl/dsc_checker.sv]
// Port-level checker for the distinct subsequence counter, bound to the top.
// Depends on dsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dsc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dsc_pkg::MATCH_W-1:0]    m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);

    // stalled result word holds
    `DSC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))
    // a taken text word always leaves a result pending
    `DSC_ASSERT_NXT(a_accept_gives_out, s_tvalid && s_tready, m_tvalid)
    // input stalls only when the output side is full
    `DSC_ASSERT(a_ready_low_full, !s_tready, m_tvalid)
    // saturation flag matches an all-ones count
    `DSC_ASSERT(a_sat_value, m_tvalid && m_tuser, m_tdata == dsc_pkg::MATCH_W'(dsc_pkg::COUNT_MAX))

endmodule

bind distinct_subsequence_counter dsc_checker u_dsc_checker (.*);

[verif/tb_distinct_subsequence_counter.sv]
// Self-checking testbench for distinct_subsequence_counter: predicts every result word
// from its own copy of the prefix counts and pattern registers and checks it field by field.
// Depends on dsc_pkg and the RTL of distinct_subsequence_counter.
`timescale 1ns / 100ps

module tb_distinct_subsequence_counter;

    localparam logic [dsc_pkg::CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        dsc_pkg::t_count count;
        logic            sat;
        logic            fin;
    } t_count_word;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [dsc_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [dsc_pkg::PAT_REG_W-1:0]  i_cfg_wdata = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = '0;   // text_byte
    logic                           s_tuser = 1'b0; // first_byte
    logic                           s_tlast = 1'b0; // last_byte
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dsc_pkg::MATCH_W-1:0]    m_tdata;        // match_count
    logic                           m_tuser;        // saturated
    logic                           m_tlast;        // is_final

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_left = 0;
    int mismatches = 0;
    int words_sent = 0;

    t_count_word pending_counts[$];

    logic [dsc_pkg::LEN_W-1:0]     cfg_len = '0;
    logic [dsc_pkg::PAT_REG_W-1:0] cfg_lo = '0;
    logic [dsc_pkg::PAT_REG_W-1:0] cfg_hi = '0;
    dsc_pkg::t_count               prefix_cnt[dsc_pkg::PATTERN_MAX];

    distinct_subsequence_counter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [7:0] pattern_at(int idx);
        if (idx < 8)
            return cfg_lo[8*idx +: 8];
        if (idx < 16)
            return cfg_hi[8*(idx-8) +: 8];
        return 8'h00;
    endfunction

    // all positions update from old neighbor values: walk from the top down
    function automatic t_count_word advance_counts(logic [7:0] text, logic first, logic last);
        t_count_word                  w;
        dsc_pkg::t_count              below;
        logic [dsc_pkg::COUNT_BITS:0] sum;
        int                           eff_len;
        if (first) begin
            foreach (prefix_cnt[j]) prefix_cnt[j] = '0;
        end
        for (int j = dsc_pkg::PATTERN_MAX; j >= 1; j--) begin
            if (pattern_at(j - 1) == text) begin
                if (j == 1)
                    below = dsc_pkg::t_count'(1);
                else
                    below = prefix_cnt[j-2];
                sum = {1'b0, prefix_cnt[j-1]} + {1'b0, below};
                prefix_cnt[j-1] = sum[dsc_pkg::COUNT_BITS] ? dsc_pkg::COUNT_MAX
                                                           : sum[dsc_pkg::COUNT_BITS-1:0];
            end
        end
        eff_len = (int'(cfg_len) > dsc_pkg::PATTERN_MAX) ? dsc_pkg::PATTERN_MAX : int'(cfg_len);
        if (eff_len == 0)
            w.count = dsc_pkg::t_count'(1);
        else
            w.count = prefix_cnt[eff_len-1];
        w.sat = (w.count == dsc_pkg::COUNT_MAX);
        w.fin = last;
        return w;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_count_word w;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected word: count=%h sat=%b fin=%b",
                             $realtime, m_tdata, m_tuser, m_tlast);
            end else begin
                w = pending_counts.pop_front();
                if (m_tdata !== w.count || m_tuser !== w.sat || m_tlast !== w.fin) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] mismatch: exp %h/%b/%b got %h/%b/%b",
                                 $realtime, w.count, w.sat, w.fin, m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold_left != 0)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver stall, counted down here
    always @(posedge i_clk) begin
        if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    task automatic send_word(logic [7:0] text, logic first, logic last);
        t_count_word w;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= text;
        s_tuser  <= first;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        w = advance_counts(text, first, last);
        pending_counts.push_back(w);
        words_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_counts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [dsc_pkg::CFG_ADDR_W-1:0] addr,
                             logic [dsc_pkg::PAT_REG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (addr)
            dsc_pkg::REG_PATTERN_LENGTH: cfg_len = data[dsc_pkg::LEN_W-1:0];
            dsc_pkg::REG_PATTERN_LOW:    cfg_lo = data;
            dsc_pkg::REG_PATTERN_HIGH:   cfg_hi = data;
            default: ;
        endcase
    endtask

    task automatic apply_pattern(logic [dsc_pkg::LEN_W-1:0] len, logic [dsc_pkg::PAT_REG_W-1:0] lo,
                                 logic [dsc_pkg::PAT_REG_W-1:0] hi, bit spare);
        wait_drained();
        repeat (3) @(posedge i_clk);
        if (spare)
            write_reg(REG_SPARE, {$urandom, $urandom});
        write_reg(dsc_pkg::REG_PATTERN_LENGTH, dsc_pkg::PAT_REG_W'(len));
        write_reg(dsc_pkg::REG_PATTERN_LOW, lo);
        write_reg(dsc_pkg::REG_PATTERN_HIGH, hi);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_pattern();
        logic [7:0]                    sym[4];
        logic [dsc_pkg::PAT_REG_W-1:0] lo;
        logic [dsc_pkg::PAT_REG_W-1:0] hi;
        logic [dsc_pkg::LEN_W-1:0]     len;
        int                            nsym;
        int                            pick;
        foreach (sym[i]) sym[i] = 8'($urandom_range(255));
        nsym = $urandom_range(1, 4);
        pick = $urandom_range(9);
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = sym[$urandom_range(nsym - 1)];
            hi[8*i +: 8] = sym[$urandom_range(nsym - 1)];
        end
        if (pick == 0) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
        end else if (pick == 1) begin
            lo = '1;
            hi = '1;
        end else if (pick == 2) begin
            lo = '0;
            hi = '0;
        end
        case ($urandom_range(9))
            0:       len = '0;
            1:       len = dsc_pkg::LEN_W'(dsc_pkg::PATTERN_MAX);
            2:       len = dsc_pkg::LEN_W'($urandom_range(dsc_pkg::PATTERN_MAX + 1, 31));
            3:       len = dsc_pkg::LEN_W'($urandom_range(9, dsc_pkg::PATTERN_MAX));
            default: len = dsc_pkg::LEN_W'($urandom_range(1, 8));
        endcase
        apply_pattern(len, lo, hi, ($urandom_range(4) == 0));
    endtask

    task automatic test_reset_defaults();
        for (int i = 0; i < 3; i++)
            send_word(8'h00, 1'b0, (i == 2));
    endtask

    // pattern 00..07,F8..FF with length clamped from 31; text walks it once, then sends one more FF
    task automatic test_directed_walk();
        apply_pattern(5'd31, 64'h0706050403020100, 64'hFFFEFDFCFBFAF9F8, 1'b1);
        for (int i = 0; i < dsc_pkg::PATTERN_MAX; i++)
            send_word(pattern_at(i), (i == 0), (i == dsc_pkg::PATTERN_MAX - 1));
        send_word(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_saturation();
        apply_pattern(dsc_pkg::LEN_W'(dsc_pkg::PATTERN_MAX), '1, '1, 1'b0);
        for (int i = 0; i < 40; i++)
            send_word(8'hFF, (i == 0), (i == 39));
        apply_pattern(5'd12, '0, '0, 1'b0);
        for (int i = 0; i < 50; i++)
            send_word(8'h00, (i == 0), (i == 49));
        // shorter pattern, counts carry on without a first mark
        apply_pattern(5'd3, '0, '0, 1'b0);
        for (int i = 0; i < 5; i++)
            send_word(8'h00, 1'b0, (i == 4));
    endtask

    task automatic test_backpressure();
        int saved_idle;
        saved_idle = tx_idle_pct;
        tx_idle_pct = 0;
        rx_hold_left <= 400;
        for (int i = 0; i < 40; i++)
            send_word(pattern_at($urandom_range(dsc_pkg::PATTERN_MAX - 1)), (i == 0), (i == 39));
        tx_idle_pct = saved_idle;
        wait_drained();
    endtask

    task automatic test_random(int n);
        int         start;
        int         tlen;
        logic [7:0] text;
        logic       first;
        logic       last;
        start = words_sent;
        while (words_sent - start < n) begin
            if ($urandom_range(99) < 30)
                random_pattern();
            tlen = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 20);
            for (int k = 0; k < tlen; k++) begin
                if ($urandom_range(4) == 0)
                    text = 8'($urandom_range(255));
                else
                    text = pattern_at($urandom_range(dsc_pkg::PATTERN_MAX - 1));
                first = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
                last  = (k == tlen - 1) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
                send_word(text, first, last);
            end
        end
    endtask

    initial begin
        foreach (prefix_cnt[j]) prefix_cnt[j] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 14;
        rx_idle_pct = 79;
        test_reset_defaults();
        test_directed_walk();
        test_saturation();
        test_random(540);

        tx_idle_pct = 79;
        rx_idle_pct = 14;
        test_backpressure();
        test_random(540);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(540);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_counts.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/dsc_pkg.sv
hdl/dsc_cell.sv
hdl/dsc_skid.sv
hdl/distinct_subsequence_counter.sv
hdl/dsc_checker.sv
verif/tb_distinct_subsequence_counter.sv
